// ===== sv/fwrl_pkg.sv =====
// Package for the per-flow fixed-window rate limiter.
// Holds shared constants, register indexes, codes and beat/slot types.
// No dependencies.
`default_nettype none
package fwrl_pkg;

    localparam int DEF_PLAYER_SLOTS = 32;
    localparam int NUM_CLASSES      = 3;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 32;

    localparam logic [1:0] CLS_ANIM  = 2'd0;
    localparam logic [1:0] CLS_LASER = 2'd1;
    localparam logic [1:0] CLS_CHUTE = 2'd2;
    localparam logic [1:0] CLS_NONE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_ANIM_WIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANIM_MAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LASER_WIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LASER_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CHUTE_WIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CHUTE_MAX = 3'd5;

    localparam logic [31:0] DEF_ANIM_WIN  = 32'd1000;
    localparam logic [15:0] DEF_ANIM_MAX  = 16'd20;
    localparam logic [31:0] DEF_LASER_WIN = 32'd1000;
    localparam logic [15:0] DEF_LASER_MAX = 16'd30;
    localparam logic [31:0] DEF_CHUTE_WIN = 32'd1000;
    localparam logic [15:0] DEF_CHUTE_MAX = 16'd12;

    localparam logic [1:0] DENY_NONE   = 2'd0;
    localparam logic [1:0] DENY_SENDER = 2'd1;
    localparam logic [1:0] DENY_LIMIT  = 2'd2;

    typedef struct packed {
        logic [1:0]        opcode;
        logic signed [7:0] player_index;
        logic              peer_present;
        logic [31:0]       connection_id;
        logic [31:0]       now_ms;
    } t_req;

    typedef struct packed {
        logic       allowed;
        logic [1:0] deny_reason;
    } t_res;

    typedef struct packed {
        logic [NUM_CLASSES-1:0][31:0] window_ms;
        logic [NUM_CLASSES-1:0][15:0] max_events;
    } t_cfg;

    typedef struct packed {
        logic [31:0] connection;
        logic [31:0] window_start;
        logic [15:0] count;
    } t_slot;

endpackage
`default_nettype wire

// ===== sv/per_flow_fixed_window_rate_limiter_top.sv =====
// Top level of the per-flow fixed-window rate limiter.
// Depends on fwrl_pkg, fwrl_cfg_regs, fwrl_slot_mem and fwrl_engine.
//
// Usage:
//   Request channel: drive i_req and raise start; the beat is taken at a
//   clock edge with start high and busy low.
//   Result channel: one beat per request on o_res, marked by o_strobe for
//   exactly one cycle; the accepting edge raises busy, which then raises
//   o_strobe. The receiver has no back-pressure; it must take every beat.
//   Config channel: i_cfg_valid / o_cfg_ready with register index and data;
//   o_cfg_ready is always high. Write only while no request is in flight.
// Pacing: a new request is taken only while busy is low. The slot read is
//   registered (synchronous memory); the update and write-back follow
//   while busy is high, so the next read always sees the written slot.
// Reset (synchronous, active low): all slots become invalid at once via
//   per-entry valid flags, registers return to their defaults, no request
//   is in flight and no result beat is pending.
`default_nettype none
module per_flow_fixed_window_rate_limiter_top
    import fwrl_pkg::*;
#(
    parameter int PLAYER_SLOTS = DEF_PLAYER_SLOTS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire t_req                  i_req,
    output logic                       o_strobe,
    output t_res                       o_res,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DEPTH = NUM_CLASSES * PLAYER_SLOTS;
    localparam int AW    = $clog2(DEPTH);

    t_cfg          cfg;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    t_slot         rd_data;
    logic          rd_valid;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_slot         wr_data;

    fwrl_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    fwrl_slot_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .o_rd_data  (rd_data),
        .o_rd_valid (rd_valid),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_data  (wr_data)
    );

    fwrl_engine #(
        .PLAYER_SLOTS (PLAYER_SLOTS),
        .AW           (AW)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .o_busy     (busy),
        .i_req      (i_req),
        .i_cfg      (cfg),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data),
        .i_rd_valid (rd_valid),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_strobe   (o_strobe),
        .o_res      (o_res)
    );

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy ##1 o_strobe)
        else $error("result beat did not follow accepted request");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_strobe && busy))
        else $error("result beat overlaps an update cycle");

    a_write_in_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> busy && !rd_en)
        else $error("slot write outside the update cycle");

    a_reason_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_res.allowed == (o_res.deny_reason == DENY_NONE)))
        else $error("allowed flag disagrees with deny reason");

endmodule
`default_nettype wire

// ===== sv/fwrl_cfg_regs.sv =====
// Configuration register file: window length and event limit per class.
// Depends on fwrl_pkg.
`default_nettype none
module fwrl_cfg_regs
    import fwrl_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ANIM_WIN:  n_cfg.window_ms[0]  = i_cfg_data;
                REG_ANIM_MAX:  n_cfg.max_events[0] = i_cfg_data[15:0];
                REG_LASER_WIN: n_cfg.window_ms[1]  = i_cfg_data;
                REG_LASER_MAX: n_cfg.max_events[1] = i_cfg_data[15:0];
                REG_CHUTE_WIN: n_cfg.window_ms[2]  = i_cfg_data;
                REG_CHUTE_MAX: n_cfg.max_events[2] = i_cfg_data[15:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_ms[0]  <= DEF_ANIM_WIN;
            r_cfg.max_events[0] <= DEF_ANIM_MAX;
            r_cfg.window_ms[1]  <= DEF_LASER_WIN;
            r_cfg.max_events[1] <= DEF_LASER_MAX;
            r_cfg.window_ms[2]  <= DEF_CHUTE_WIN;
            r_cfg.max_events[2] <= DEF_CHUTE_MAX;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule
`default_nettype wire

// ===== sv/fwrl_slot_mem.sv =====
// Slot store: one-read one-write synchronous memory of slot records plus
// per-entry valid flags cleared at reset. Depends on fwrl_pkg.
`default_nettype none
module fwrl_slot_mem
    import fwrl_pkg::*;
#(
    parameter int DEPTH = NUM_CLASSES * DEF_PLAYER_SLOTS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output t_slot              o_rd_data,
    output logic               o_rd_valid,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_slot         i_wr_data
);

    t_slot            r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    t_slot            r_rd_data;
    logic             r_rd_valid;

    assign o_rd_data  = r_rd_data;
    assign o_rd_valid = r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/fwrl_engine.sv =====
// Request sequencer: on accept, issues the slot read for a valid sender,
// then decides the window restart and limit, writes the slot back (valid
// senders only) and emits the result beat. Depends on fwrl_pkg.
`default_nettype none
module fwrl_engine
    import fwrl_pkg::*;
#(
    parameter int PLAYER_SLOTS = DEF_PLAYER_SLOTS,
    parameter int AW           = $clog2(NUM_CLASSES * PLAYER_SLOTS)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    output logic               o_busy,
    input  wire t_req          i_req,
    input  wire t_cfg          i_cfg,
    output logic               o_rd_en,
    output logic [AW-1:0]      o_rd_addr,
    input  wire t_slot         i_rd_data,
    input  wire logic          i_rd_valid,
    output logic               o_wr_en,
    output logic [AW-1:0]      o_wr_addr,
    output t_slot              o_wr_data,
    output logic               o_strobe,
    output t_res               o_res
);

    localparam logic [7:0]    SLOTS_B = 8'(PLAYER_SLOTS);
    localparam logic [AW-1:0] BASE1   = AW'(PLAYER_SLOTS);
    localparam logic [AW-1:0] BASE2   = AW'(2 * PLAYER_SLOTS);

    logic          r_busy;
    logic          r_ok;
    t_req          r_req;
    logic [AW-1:0] r_addr;
    logic          r_strobe;
    t_res          r_res;

    logic          accept;
    logic [7:0]    idx_u;
    logic          sender_ok;
    logic [AW-1:0] base;
    logic [AW-1:0] addr;

    logic [31:0]   win;
    logic [15:0]   lim;
    logic [31:0]   elapsed;
    logic          restart;
    logic [15:0]   cnt_base;
    logic          over;
    t_slot         wr_data;
    t_res          n_res;

    assign accept = i_start && !r_busy;
    assign idx_u  = unsigned'(i_req.player_index);

    assign sender_ok = (i_req.opcode != CLS_NONE) && !idx_u[7] && (idx_u < SLOTS_B)
                       && i_req.peer_present;

    always_comb begin
        case (i_req.opcode)
            CLS_LASER: base = BASE1;
            CLS_CHUTE: base = BASE2;
            default:   base = '0;
        endcase
        addr = base + AW'(idx_u[6:0]);
    end

    always_comb begin
        case (r_req.opcode)
            CLS_LASER: begin
                win = i_cfg.window_ms[1];
                lim = i_cfg.max_events[1];
            end
            CLS_CHUTE: begin
                win = i_cfg.window_ms[2];
                lim = i_cfg.max_events[2];
            end
            default: begin
                win = i_cfg.window_ms[0];
                lim = i_cfg.max_events[0];
            end
        endcase
        elapsed = r_req.now_ms - i_rd_data.window_start;
        restart = !i_rd_valid || (i_rd_data.connection != r_req.connection_id)
                  || (elapsed >= win);
        cnt_base = restart ? 16'd0 : i_rd_data.count;
        over     = cnt_base >= lim;

        wr_data.connection   = r_req.connection_id;
        wr_data.window_start = restart ? r_req.now_ms : i_rd_data.window_start;
        wr_data.count        = over ? cnt_base : cnt_base + 16'd1;

        if (!r_ok) begin
            n_res.allowed     = 1'b0;
            n_res.deny_reason = DENY_SENDER;
        end else if (over) begin
            n_res.allowed     = 1'b0;
            n_res.deny_reason = DENY_LIMIT;
        end else begin
            n_res.allowed     = 1'b1;
            n_res.deny_reason = DENY_NONE;
        end
    end

    assign o_busy    = r_busy;
    assign o_rd_en   = accept && sender_ok;
    assign o_rd_addr = addr;
    assign o_wr_en   = r_busy && r_ok;
    assign o_wr_addr = r_addr;
    assign o_wr_data = wr_data;
    assign o_strobe  = r_strobe;
    assign o_res     = r_res;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req  <= i_req;
            r_ok   <= sender_ok;
            r_addr <= addr;
        end
        if (r_busy) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_busy   <= accept;
            r_strobe <= r_busy;
        end
    end

endmodule
`default_nettype wire

// ===== bench/tb_per_flow_fixed_window_rate_limiter_top.sv =====
// Self-checking bench for per_flow_fixed_window_rate_limiter_top: directed table then random phases.
// Untyped requests have their verdict predicted from a local copy of the slot table and class settings;
// typed table rows carry their own expected verdict. Depends on fwrl_pkg and the rate limiter RTL.
module tb_per_flow_fixed_window_rate_limiter_top;
    timeunit 1ns;
    timeprecision 1ps;
    import fwrl_pkg::*;

    localparam int PLAYER_SLOTS = DEF_PLAYER_SLOTS;
    localparam int ENTRIES      = NUM_CLASSES * PLAYER_SLOTS;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    localparam t_res ALLOW      = '{allowed: 1'b1, deny_reason: DENY_NONE};
    localparam t_res BAD_SENDER = '{allowed: 1'b0, deny_reason: DENY_SENDER};
    localparam t_res WORKED_OUT = '0;

    typedef struct {
        t_req req;
        bit   typed;
        t_res want;
    } plan_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_req                  i_req;
    logic                  o_strobe;
    t_res                  o_res;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    per_flow_fixed_window_rate_limiter_top #(.PLAYER_SLOTS(PLAYER_SLOTS)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_strobe    (o_strobe),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // local copy of the block's state
    logic [31:0] class_window [NUM_CLASSES];
    logic [15:0] class_quota  [NUM_CLASSES];
    logic        slot_live    [ENTRIES];
    logic [31:0] slot_owner   [ENTRIES];
    logic [31:0] slot_opened  [ENTRIES];
    logic [15:0] slot_tally   [ENTRIES];

    t_res        verdicts_due [$];
    t_res        beat_want;
    plan_row     plan [20];
    int          idle_pct;
    logic [31:0] t_now;
    logic [31:0] conn_pool [2];
    int          n_sent, n_checked, n_allowed, n_limited, n_cfg, n_fail;

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic t_req mk(logic [1:0] op, logic [7:0] idx, logic peer,
                                logic [31:0] conn, logic [31:0] now);
        t_req r;
        r.opcode        = op;
        r.player_index  = idx;
        r.peer_present  = peer;
        r.connection_id = conn;
        r.now_ms        = now;
        return r;
    endfunction

    function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        case (idx)
            REG_ANIM_WIN:  class_window[CLS_ANIM]  = val;
            REG_ANIM_MAX:  class_quota[CLS_ANIM]   = val[15:0];
            REG_LASER_WIN: class_window[CLS_LASER] = val;
            REG_LASER_MAX: class_quota[CLS_LASER]  = val[15:0];
            REG_CHUTE_WIN: class_window[CLS_CHUTE] = val;
            REG_CHUTE_MAX: class_quota[CLS_CHUTE]  = val[15:0];
            default: ;
        endcase
    endfunction

    function automatic t_res judge_event(t_req r);
        t_res        v;
        logic [7:0]  raw;
        logic [1:0]  c;
        logic [31:0] age;
        int          e;
        v   = BAD_SENDER;
        raw = r.player_index;
        c   = r.opcode;
        if (c == CLS_NONE || raw[7] || raw >= PLAYER_SLOTS || !r.peer_present)
            return v;
        e   = int'(c) * PLAYER_SLOTS + int'(raw);
        age = r.now_ms - slot_opened[e];
        if (!slot_live[e] || slot_owner[e] != r.connection_id || age >= class_window[c]) begin
            slot_live[e]   = 1'b1;
            slot_owner[e]  = r.connection_id;
            slot_opened[e] = r.now_ms;
            slot_tally[e]  = '0;
        end
        if (slot_tally[e] >= class_quota[c]) begin
            v.allowed     = 1'b0;
            v.deny_reason = DENY_LIMIT;
        end else begin
            slot_tally[e] = slot_tally[e] + 16'd1;
            v = ALLOW;
        end
        return v;
    endfunction

    function automatic t_req make_req(int step_max);
        t_req r;
        int   roll;
        roll = $urandom_range(99);
        r.opcode = (roll < 4) ? CLS_NONE : 2'($urandom_range(CLS_CHUTE));
        roll = $urandom_range(99);
        if (roll < 8)
            r.player_index = 8'($urandom_range(255));
        else if (roll < 70)
            r.player_index = ($urandom_range(2) == 0) ? 8'(PLAYER_SLOTS - 1) :
                             8'($urandom_range(1));
        else
            r.player_index = 8'($urandom_range(PLAYER_SLOTS - 1));
        r.peer_present = ($urandom_range(99) < 95);
        roll = $urandom_range(99);
        if (roll < 80)
            r.connection_id = conn_pool[0];
        else if (roll < 90)
            r.connection_id = conn_pool[1];
        else
            r.connection_id = $urandom;
        if ($urandom_range(99) < 3)
            t_now = $urandom;
        else
            t_now = t_now + 32'($urandom_range(step_max));
        r.now_ms = t_now;
        return r;
    endfunction

    task automatic send_req(t_req r, bit typed, t_res want);
        int   gap;
        t_res v;
        gap = 0;
        while (gap < 60 && $urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            i_req <= $bits(t_req)'({$urandom, $urandom, $urandom});
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy !== 1'b0);
        v = judge_event(r);
        verdicts_due.push_back(typed ? want : v);
        n_sent++;
    endtask

    task automatic stop_and_drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        apply_cfg(idx, val);
        n_cfg++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_classes(logic [31:0] aw, logic [31:0] am, logic [31:0] lw,
                               logic [31:0] lm, logic [31:0] cw, logic [31:0] cm);
        cfg_write(REG_ANIM_WIN,  aw);
        cfg_write(REG_ANIM_MAX,  am);
        cfg_write(REG_LASER_WIN, lw);
        cfg_write(REG_LASER_MAX, lm);
        cfg_write(REG_CHUTE_WIN, cw);
        cfg_write(REG_CHUTE_MAX, cm);
    endtask

    task automatic run_phase(int idle, int step_max, int n);
        idle_pct = idle;
        repeat (n) send_req(make_req(step_max), 1'b0, WORKED_OUT);
        stop_and_drain();
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (verdicts_due.size() == 0) begin
                $error("result beat with no request outstanding");
                n_fail++;
            end else begin
                beat_want = verdicts_due.pop_front();
                n_checked++;
                if (o_res.allowed !== beat_want.allowed) begin
                    $error("allowed: expected %0d, got %0d", beat_want.allowed, o_res.allowed);
                    n_fail++;
                end
                if (o_res.deny_reason !== beat_want.deny_reason) begin
                    $error("deny_reason: expected %0d, got %0d",
                           beat_want.deny_reason, o_res.deny_reason);
                    n_fail++;
                end
                if (beat_want.allowed)
                    n_allowed++;
                else if (beat_want.deny_reason == DENY_LIMIT)
                    n_limited++;
            end
        end
    end

    initial begin
        #1_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        idle_pct    = 0;
        t_now       = '0;
        conn_pool[0] = $urandom;
        conn_pool[1] = $urandom;
        n_sent = 0; n_checked = 0; n_allowed = 0; n_limited = 0; n_cfg = 0; n_fail = 0;
        class_window[CLS_ANIM]  = DEF_ANIM_WIN;
        class_quota[CLS_ANIM]   = DEF_ANIM_MAX;
        class_window[CLS_LASER] = DEF_LASER_WIN;
        class_quota[CLS_LASER]  = DEF_LASER_MAX;
        class_window[CLS_CHUTE] = DEF_CHUTE_WIN;
        class_quota[CLS_CHUTE]  = DEF_CHUTE_MAX;
        for (int k = 0; k < ENTRIES; k++) begin
            slot_live[k]   = 1'b0;
            slot_owner[k]  = '0;
            slot_opened[k] = '0;
            slot_tally[k]  = '0;
        end

        plan = '{
            '{mk(CLS_ANIM,  8'd0,   1'b1, 32'h1,          32'h0),          1'b1, ALLOW},
            '{mk(CLS_ANIM,  8'h80,  1'b1, 32'h1,          32'h0),          1'b1, BAD_SENDER},
            '{mk(CLS_LASER, 8'h7F,  1'b1, 32'h1,          32'h0),          1'b1, BAD_SENDER},
            '{mk(CLS_CHUTE, 8'd32,  1'b1, 32'h1,          32'h0),          1'b1, BAD_SENDER},
            '{mk(CLS_CHUTE, 8'hFF,  1'b1, 32'h1,          32'h0),          1'b1, BAD_SENDER},
            '{mk(CLS_CHUTE, 8'd31,  1'b0, 32'h1,          32'h0),          1'b1, BAD_SENDER},
            '{mk(CLS_NONE,  8'd1,   1'b1, 32'h1,          32'h0),          1'b1, BAD_SENDER},
            '{mk(CLS_CHUTE, 8'd31,  1'b1, 32'hFFFF_FFFF,  32'hFFFF_FFFF),  1'b1, ALLOW},
            '{mk(CLS_CHUTE, 8'd31,  1'b1, 32'hFFFF_FFFF,  32'h0),          1'b0, WORKED_OUT},
            '{mk(CLS_CHUTE, 8'd31,  1'b1, 32'hFFFF_FFFF,  32'd998),        1'b0, WORKED_OUT},
            '{mk(CLS_CHUTE, 8'd31,  1'b1, 32'hFFFF_FFFF,  32'd999),        1'b0, WORKED_OUT},
            '{mk(CLS_ANIM,  8'd0,   1'b1, 32'h8000_0000,  32'd5),          1'b0, WORKED_OUT},
            '{mk(CLS_ANIM,  8'd0,   1'b1, 32'h8000_0000,  32'd1004),       1'b0, WORKED_OUT},
            '{mk(CLS_ANIM,  8'd0,   1'b1, 32'h8000_0000,  32'd1005),       1'b0, WORKED_OUT},
            '{mk(CLS_ANIM,  8'd0,   1'b1, 32'h1,          32'd1005),       1'b0, WORKED_OUT},
            '{mk(CLS_LASER, 8'd0,   1'b1, 32'h0,          32'h0),          1'b1, ALLOW},
            '{mk(CLS_LASER, 8'd31,  1'b1, 32'hFFFF_FFFF,  32'h7FFF_FFFF),  1'b1, ALLOW},
            '{mk(CLS_LASER, 8'd31,  1'b0, 32'hFFFF_FFFF,  32'h7FFF_FFFF),  1'b1, BAD_SENDER},
            '{mk(CLS_NONE,  8'h80,  1'b0, 32'h0,          32'h0),          1'b1, BAD_SENDER},
            '{mk(CLS_ANIM,  8'd1,   1'b1, 32'h1,          32'hFFFF_FFFF),  1'b1, ALLOW}
        };

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) send_req(plan[i].req, plan[i].typed, plan[i].want);
        stop_and_drain();

        // short window, zero quota, zero window with a full-width quota
        set_classes(32'd50, 32'd3, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'hABCD_FFFF);
        run_phase(0, 20, 200);

        // a minimum animation window, small quotas, upper data bits ignored
        set_classes(32'd1, 32'd1, 32'd100, 32'd2, 32'd7, 32'h0001_0005);
        cfg_write(REG_SPARE_A, $urandom);
        cfg_write(REG_SPARE_B, $urandom);
        run_phase(81, 3, 200);

        // long windows let counts build up ...
        set_classes(32'hFFFF_FFFF, 32'd8, 32'hFFFF_FFFF, 32'd6, 32'hFFFF_FFFF, 32'd10);
        run_phase(34, 50, 200);

        // ... then quotas drop below the held counts
        set_classes(32'hFFFF_FFFF, 32'd2, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd0);
        run_phase(81, 50, 200);

        if (verdicts_due.size() != 0) begin
            $error("%0d expected results never arrived", verdicts_due.size());
            n_fail++;
        end
        $display("Covered %0d requests over five settings, %0d register writes.", n_sent, n_cfg);
        $display("Checked %0d verdicts: %0d allowed, %0d over limit, %0d mismatches.",
                 n_checked, n_allowed, n_limited, n_fail);
        if (n_fail == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/fwrl_pkg.sv
sv/fwrl_cfg_regs.sv
sv/fwrl_slot_mem.sv
sv/fwrl_engine.sv
sv/per_flow_fixed_window_rate_limiter_top.sv
bench/tb_per_flow_fixed_window_rate_limiter_top.sv
